// ----- sv/atilt_pkg.sv -----
package atilt_pkg;

  localparam int CordicIterations = 16;
  localparam int AngleFractionBits = 7;
  localparam int ItCntW = $clog2(CordicIterations + 1);
  localparam int SqW = 33;
  localparam int RootW = 17;
  localparam int CwW = 40;
  localparam int ZW = 24;
  localparam int RawW = 12;
  localparam int DiffW = 20;
  localparam logic signed [DiffW-1:0] AngLimit = DiffW'(336 <<< AngleFractionBits);

  localparam logic [1:0] CfgCorrX = 2'd0;
  localparam logic [1:0] CfgCorrY = 2'd1;
  localparam logic [1:0] CfgApply = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_SQRT_INIT, ST_SQRT, ST_CORD_INIT, ST_CORD, ST_CORD_DONE,
    ST_FINISH, ST_OUT
  } atilt_state_t;

  typedef struct packed {
    logic load;
    logic sq;
    logic sqrt_init;
    logic sqrt_step;
    logic cord_init;
    logic cord_step;
    logic cord_done;
    logic pass_sel;
    logic finish;
  } atilt_cmd_t;

  typedef struct packed {
    logic sqrt_last;
    logic cord_last;
  } atilt_stat_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0: v = 24'sd2949120;  5'd1: v = 24'sd1740967;  5'd2: v = 24'sd919879;
      5'd3: v = 24'sd466945;   5'd4: v = 24'sd234379;   5'd5: v = 24'sd117304;
      5'd6: v = 24'sd58666;    5'd7: v = 24'sd29335;    5'd8: v = 24'sd14668;
      5'd9: v = 24'sd7334;     5'd10: v = 24'sd3667;    5'd11: v = 24'sd1833;
      5'd12: v = 24'sd917;     5'd13: v = 24'sd458;     5'd14: v = 24'sd229;
      5'd15: v = 24'sd115;     5'd16: v = 24'sd57;      5'd17: v = 24'sd29;
      5'd18: v = 24'sd14;      5'd19: v = 24'sd7;       5'd20: v = 24'sd4;
      5'd21: v = 24'sd2;       5'd22: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/atilt_ctrl.sv -----
module atilt_ctrl
  import atilt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  atilt_stat_t stat,
  output atilt_cmd_t  cmd
);

  atilt_state_t state_r, state_nxt;
  logic pass_r, pass_nxt;
  logic oval_r, oval_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r <= 1'b0;
      oval_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r <= pass_nxt;
      oval_r <= oval_nxt;
    end
  end

  assign out_valid = oval_r;

  always_comb begin
    state_nxt = state_r;
    pass_nxt = pass_r;
    oval_nxt = oval_r;
    cmd = '0;
    cmd.pass_sel = pass_r;
    in_ready = 1'b0;
    if (oval_r && out_ready) oval_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          pass_nxt = 1'b0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        state_nxt = ST_SQRT_INIT;
      end
      ST_SQRT_INIT: begin
        cmd.sqrt_init = 1'b1;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) state_nxt = ST_CORD_INIT;
      end
      ST_CORD_INIT: begin
        cmd.cord_init = 1'b1;
        state_nxt = ST_CORD;
      end
      ST_CORD: begin
        cmd.cord_step = 1'b1;
        if (stat.cord_last) state_nxt = ST_CORD_DONE;
      end
      ST_CORD_DONE: begin
        cmd.cord_done = 1'b1;
        if (pass_r) begin
          state_nxt = ST_FINISH;
        end else begin
          pass_nxt = 1'b1;
          state_nxt = ST_CORD_INIT;
        end
      end
      ST_FINISH: begin
        if (!oval_nxt) begin
          cmd.finish = 1'b1;
          oval_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/atilt_dp.sv -----
module atilt_dp
  import atilt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  atilt_cmd_t         cmd,
  output atilt_stat_t        stat,
  input  logic               in_command,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [6:0]  corr_x,
  input  logic signed [6:0]  corr_y,
  input  logic               apply,
  output logic signed [16:0] roll_angle,
  output logic signed [16:0] pitch_angle
);

  logic signed [15:0] ax_r, ay_r, az_r;
  logic cap_r;
  logic [SqW-1:0] vxz_r, vyz_r;
  logic [SqW-1:0] rxz_r, ryz_r;
  logic [4:0] scnt_r;
  logic [SqW-1:0] bit_w;
  logic [SqW-1:0] vxz_nxt, vyz_nxt, rxz_nxt, ryz_nxt;
  logic signed [CwW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [ItCntW-1:0] ccnt_r;
  logic zero_r;
  logic signed [RawW+4:0] rroll_r, rpitch_r;
  logic signed [15:0] zroll_r, zpitch_r;
  logic signed [16:0] roll_r, pitch_r;
  logic signed [ZW-1:0] zr;
  logic signed [RawW+4:0] ang;
  logic signed [31:0] sqx, sqy, sqz;

  assign bit_w = SqW'(1) << {scnt_r, 1'b0};
  assign stat.sqrt_last = (scnt_r == 5'd0);
  assign stat.cord_last = (ccnt_r == ItCntW'(CordicIterations - 1));

  function automatic void sq_step(input logic [SqW-1:0] v, input logic [SqW-1:0] r,
                                  input logic [SqW-1:0] b,
                                  output logic [SqW-1:0] vo, output logic [SqW-1:0] ro);
    if (v >= r + b) begin
      vo = v - (r + b);
      ro = (r >> 1) + b;
    end else begin
      vo = v;
      ro = r >> 1;
    end
  endfunction

  always_comb begin
    sq_step(vxz_r, rxz_r, bit_w, vxz_nxt, rxz_nxt);
    sq_step(vyz_r, ryz_r, bit_w, vyz_nxt, ryz_nxt);
  end

  function automatic logic signed [DiffW-1:0] fin(input logic signed [RawW+4:0] raw,
                                                  input logic signed [15:0] off,
                                                  input logic signed [6:0] corr,
                                                  input logic ap);
    logic signed [DiffW-1:0] d;
    d = DiffW'(raw) - DiffW'(off);
    if (ap) d = ((d + (d <<< 1) + DiffW'(1)) >>> 1) + (DiffW'(corr) <<< AngleFractionBits);
    if (d > AngLimit) d = AngLimit;
    else if (d < -AngLimit) d = -AngLimit;
    return d;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [RawW+4:0] v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return 16'(v);
  endfunction

  assign zr = cz_r + (ZW'(1) <<< (15 - AngleFractionBits));
  assign ang = zero_r ? '0 : (RawW+5)'(zr >>> (16 - AngleFractionBits));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zroll_r <= '0;
      zpitch_r <= '0;
    end else if (cmd.finish && cap_r) begin
      zroll_r <= sat16(rroll_r);
      zpitch_r <= sat16(rpitch_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
      cap_r <= in_command;
    end
    if (cmd.sq) begin
      vxz_r <= SqW'($unsigned(sqx)) + SqW'($unsigned(sqz));
      vyz_r <= SqW'($unsigned(sqy)) + SqW'($unsigned(sqz));
    end
    if (cmd.sqrt_init) begin
      rxz_r <= '0;
      ryz_r <= '0;
      scnt_r <= 5'd16;
    end
    if (cmd.sqrt_step) begin
      vxz_r <= vxz_nxt;
      vyz_r <= vyz_nxt;
      rxz_r <= rxz_nxt;
      ryz_r <= ryz_nxt;
      scnt_r <= scnt_r - 5'd1;
    end
    if (cmd.cord_init) begin
      if (!cmd.pass_sel) begin
        cx_r <= CwW'(rxz_r[RootW-1:0]) <<< 14;
        cy_r <= CwW'(ay_r) <<< 14;
        zero_r <= (ay_r == 0) && (rxz_r == 0);
      end else begin
        cx_r <= CwW'(ryz_r[RootW-1:0]) <<< 14;
        cy_r <= CwW'(ax_r) <<< 14;
        zero_r <= (ax_r == 0) && (ryz_r == 0);
      end
      cz_r <= '0;
      ccnt_r <= '0;
    end
    if (cmd.cord_step) begin
      if (cy_r >= 0) begin
        cx_r <= cx_r + (cy_r >>> ccnt_r);
        cy_r <= cy_r - (cx_r >>> ccnt_r);
        cz_r <= cz_r + atan_q16(5'(ccnt_r));
      end else begin
        cx_r <= cx_r - (cy_r >>> ccnt_r);
        cy_r <= cy_r + (cx_r >>> ccnt_r);
        cz_r <= cz_r - atan_q16(5'(ccnt_r));
      end
      ccnt_r <= ccnt_r + 1'b1;
    end
    if (cmd.cord_done) begin
      if (!cmd.pass_sel) rroll_r <= ang;
      else rpitch_r <= -ang;
    end
    if (cmd.finish) begin
      roll_r <= 17'(fin(rroll_r, zroll_r, corr_x, apply));
      pitch_r <= 17'(fin(rpitch_r, zpitch_r, corr_y, apply));
    end
  end

  assign sqx = ax_r * ax_r;
  assign sqy = ay_r * ay_r;
  assign sqz = az_r * az_r;
  assign roll_angle = roll_r;
  assign pitch_angle = pitch_r;

endmodule

// ----- sv/accel_tilt_angle_with_zero_offset.sv -----
// Accelerometer tilt angles (roll and pitch) with stored zero offsets.
// A request on the in_ channel carries one accelerometer sample and a command:
// 0 measures, 1 also captures the raw angles of this sample as new offsets.
// The result on the out_ channel gives roll and pitch in 1/128 degree,
// measured against the offsets in force before this request.
// The cfg_ channel writes correction_x (0), correction_y (1) and
// apply_correction (2); other indexes are ignored. Write only while idle.
// From acceptance to out_valid a request passes the setup steps (squaring
// and square-root init), a shared two-lane integer square root, two CORDIC
// vectoring passes (load, 16 iterations, store) on one shared rotator,
// and a finish step.
// One request is in flight at a time; no new request is taken until it is done.
// A finished result waits in the output register while the next request is
// already being worked on; the block stalls only before overwriting it.
// Reset clears offsets to zero, corrections to zero and apply_correction to 1.
module accel_tilt_angle_with_zero_offset
  import atilt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_command,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [16:0] out_roll_angle,
  output logic signed [16:0] out_pitch_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [6:0]         cfg_data
);

  atilt_cmd_t cmd;
  atilt_stat_t stat;
  logic signed [6:0] corr_x_r, corr_y_r;
  logic apply_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_x_r <= '0;
      corr_y_r <= '0;
      apply_r <= 1'b1;
    end else if (cfg_valid) begin
      if (cfg_index == CfgCorrX) corr_x_r <= cfg_data;
      else if (cfg_index == CfgCorrY) corr_y_r <= cfg_data;
      else if (cfg_index == CfgApply) apply_r <= cfg_data[0];
    end
  end

  atilt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  atilt_dp u_dp (
    .clk, .rst_n, .cmd, .stat, .in_command, .in_accel_x, .in_accel_y, .in_accel_z,
    .corr_x(corr_x_r), .corr_y(corr_y_r), .apply(apply_r),
    .roll_angle(out_roll_angle), .pitch_angle(out_pitch_angle)
  );

endmodule

// ----- sv/atilt_checker.sv -----
module atilt_checker
  import atilt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [16:0] out_roll_angle,
  input logic signed [16:0] out_pitch_angle
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_roll_angle)) else $error("out held");
  a_roll_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_angle <= 17'sd43008 && out_roll_angle >= -17'sd43008)
    else $error("roll range");
  a_pitch_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pitch_angle <= 17'sd43008 && out_pitch_angle >= -17'sd43008)
    else $error("pitch range");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("busy");

endmodule

bind accel_tilt_angle_with_zero_offset atilt_checker u_chk (.*);
